/* src/usb_config_descriptor_walk_macros.svh */
// Assertion macros shared by the descriptor walk RTL.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef USB_CONFIG_DESCRIPTOR_WALK_MACROS_SVH
`define USB_CONFIG_DESCRIPTOR_WALK_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define UCDW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UCDW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ucdw_pkg.sv */
// Package for the configuration descriptor walk: codes, limits and shared types.
// No dependencies.
package ucdw_pkg;

    localparam int TABLE_SLOTS_DEF = 8;
    localparam int HEAD_DEPTH_DEF  = 8;

    // commands
    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_FEED  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    // report status
    localparam logic [1:0] ST_COMMIT    = 2'd0;
    localparam logic [1:0] ST_PARTIAL   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // descriptor types and minimum lengths
    localparam logic [7:0] TYPE_CONFIG = 8'd2;
    localparam logic [7:0] TYPE_IFACE  = 8'd4;
    localparam logic [7:0] TYPE_EP     = 8'd5;
    localparam logic [7:0] CONFIG_LEN  = 8'd9;
    localparam logic [7:0] IFACE_LEN   = 8'd9;
    localparam logic [7:0] EP_LEN      = 8'd7;
    localparam logic [7:0] MIN_LEN     = 8'd2;
    localparam logic [1:0] XFER_ISO    = 2'd1;

    localparam logic [7:0] IVAL_MIN = 8'd1;
    localparam logic [7:0] IVAL_MAX = 8'd16;

    // endpoint to be recorded
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] ival;
        logic [7:0] iface;
        logic [7:0] alt;
        logic       ok;
    } t_ep_req;

    // outcome of one table scan step
    typedef struct packed {
        logic done;
        logic dup;
        logic drop;
    } t_scan_evt;

    // one slot as seen by the report
    typedef struct packed {
        logic       used;
        logic [7:0] addr;
        logic [4:0] ival;
        logic [7:0] iface;
        logic [7:0] alt;
        logic       unusable;
    } t_slot_view;

endpackage

/* src/ucdw_slot_table.sv */
// Endpoint slot table with a one-slot-per-cycle scan for duplicates and a free slot.
// Depends on ucdw_pkg.
module ucdw_slot_table #(
    parameter int TABLE_SLOTS = ucdw_pkg::TABLE_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_start,
    input  ucdw_pkg::t_ep_req    i_req,
    input  logic [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1)-1:0] i_rd_idx,
    output ucdw_pkg::t_scan_evt  o_evt,
    output ucdw_pkg::t_slot_view o_rd
);
    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(TABLE_SLOTS - 1);

    logic [TABLE_SLOTS-1:0] r_valid;
    logic [7:0]             r_addr     [TABLE_SLOTS];
    logic [4:0]             r_ival     [TABLE_SLOTS];
    logic [7:0]             r_iface    [TABLE_SLOTS];
    logic [7:0]             r_alt      [TABLE_SLOTS];
    logic                   r_unusable [TABLE_SLOTS];
    logic                   r_busy;
    logic [SW-1:0]          r_idx;
    ucdw_pkg::t_ep_req      r_req;

    logic hit_valid, hit_match;

    assign hit_valid = r_valid[r_idx];
    assign hit_match = (r_addr[r_idx] == r_req.addr) && (r_iface[r_idx] == r_req.iface)
                    && (r_alt[r_idx] == r_req.alt);

    always_comb begin
        o_evt.dup  = r_busy && hit_valid && hit_match;
        o_evt.drop = r_busy && hit_valid && !hit_match && (r_idx == LAST_IDX);
        o_evt.done = r_busy && (!hit_valid || hit_match || (r_idx == LAST_IDX));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
            r_busy  <= 1'b0;
            r_idx   <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy) begin
            if (!hit_valid) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (o_evt.done) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req <= i_req;
        end
        if (r_busy && !hit_valid) begin
            r_addr[r_idx]     <= r_req.addr;
            r_ival[r_idx]     <= r_req.ok ? r_req.ival[4:0] : 5'd0;
            r_iface[r_idx]    <= r_req.iface;
            r_alt[r_idx]      <= r_req.alt;
            r_unusable[r_idx] <= !r_req.ok;
        end else if (o_evt.dup && ({3'b000, r_ival[r_idx]} != r_req.ival)) begin
            r_unusable[r_idx] <= 1'b1;
        end
    end

    always_comb begin
        o_rd.used     = r_valid[i_rd_idx];
        o_rd.addr     = r_valid[i_rd_idx] ? r_addr[i_rd_idx]     : 8'd0;
        o_rd.ival     = r_valid[i_rd_idx] ? r_ival[i_rd_idx]     : 5'd0;
        o_rd.iface    = r_valid[i_rd_idx] ? r_iface[i_rd_idx]    : 8'd0;
        o_rd.alt      = r_valid[i_rd_idx] ? r_alt[i_rd_idx]      : 8'd0;
        o_rd.unusable = r_valid[i_rd_idx] ? r_unusable[i_rd_idx] : 1'b0;
    end

endmodule

/* src/usb_config_descriptor_walk.sv */
// Top level of the configuration descriptor walk: byte framing, fold and report.
// Depends on ucdw_pkg, ucdw_slot_table and usb_config_descriptor_walk_macros.svh.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------
//   input   | in        | i_valid / o_stall   | i_command, i_data_byte
//   output  | out       | o_valid / i_stall   | o_status .. o_last, one item per slot
//
// Begin and ignored commands leave the sequencer idle. A feed passes through the
// feed state, then the fold state when it closes a descriptor, and an isochronous
// endpoint adds a table scan, one slot per cycle through its single compare unit.
// An end streams TABLE_SLOTS items, one per cycle while i_stall is low.
// o_stall is high whenever the sequencer is busy; i_stall holds the current slot.
// Reset (synchronous, active low) empties the table and clears the walk control state.
`include "usb_config_descriptor_walk_macros.svh"

module usb_config_descriptor_walk #(
    parameter int TABLE_SLOTS = ucdw_pkg::TABLE_SLOTS_DEF,
    parameter int HEAD_DEPTH  = ucdw_pkg::HEAD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_config_value,
    output logic        o_slot_used,
    output logic [7:0]  o_ep_address,
    output logic [4:0]  o_ep_interval,
    output logic [7:0]  o_ep_interface,
    output logic [7:0]  o_ep_alternate,
    output logic        o_ep_unusable,
    output logic [15:0] o_dropped_count,
    output logic [15:0] o_bad_interval_count,
    output logic [15:0] o_bad_descriptor_count,
    output logic        o_last
);
    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int HW = $clog2(HEAD_DEPTH);
    localparam logic [SW-1:0] LAST_IDX = SW'(TABLE_SLOTS - 1);
    localparam logic [7:0]    HEAD_LIM = 8'(HEAD_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FEED   = 3'd1;
    localparam logic [2:0] S_FOLD   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    logic [2:0]  r_state;
    logic        r_bad, r_started, r_in_iface;
    logic [15:0] r_total, r_rcv;
    logic [7:0]  r_dlen, r_pos, r_fold_len;
    logic [7:0]  r_cur_iface, r_cur_alt, r_cfg_value;
    logic [7:0]  r_head [HEAD_DEPTH];
    logic [7:0]  r_byte;
    logic [15:0] r_dropped, r_bad_ival, r_bad_desc;
    logic [1:0]  r_status;
    logic [SW-1:0] r_idx;

    logic        accept, clear, tbl_start;
    logic        feed_go, new_desc, short_len, closes;
    logic [7:0]  eff_len, eff_pos, pos_inc;
    logic        ival_ok;
    logic        inc_drop, inc_ival, inc_desc;
    logic [15:0] total_from_head;
    ucdw_pkg::t_ep_req    ep_req;
    ucdw_pkg::t_scan_evt  scan_evt;
    ucdw_pkg::t_slot_view slot_rd;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign clear   = accept && (i_command == ucdw_pkg::CMD_BEGIN);

    // byte framing for the feed cycle
    assign feed_go   = !r_bad && !(r_started && (r_rcv >= r_total));
    assign new_desc  = (r_dlen == 8'd0);
    assign short_len = new_desc && (r_byte < ucdw_pkg::MIN_LEN);
    assign eff_len   = new_desc ? r_byte : r_dlen;
    assign eff_pos   = new_desc ? 8'd0 : r_pos;
    assign pos_inc   = eff_pos + 8'd1;
    assign closes    = (pos_inc == eff_len);

    assign total_from_head = {r_head[3], r_head[2]};
    assign ival_ok = (r_head[6] >= ucdw_pkg::IVAL_MIN) && (r_head[6] <= ucdw_pkg::IVAL_MAX);

    // send an iso endpoint with context and nonzero address to the table; count faults
    always_comb begin
        tbl_start = 1'b0;
        inc_ival  = 1'b0;
        inc_desc  = 1'b0;
        if (r_state == S_FOLD && r_started) begin
            if (r_head[1] == ucdw_pkg::TYPE_IFACE) begin
                inc_desc = (r_fold_len < ucdw_pkg::IFACE_LEN);
            end else if (r_head[1] == ucdw_pkg::TYPE_EP) begin
                if (r_fold_len < ucdw_pkg::EP_LEN) begin
                    inc_desc = 1'b1;
                end else if (r_head[3][1:0] == ucdw_pkg::XFER_ISO) begin
                    if (!r_in_iface || r_head[2] == 8'd0) begin
                        inc_desc = 1'b1;
                    end else begin
                        tbl_start = 1'b1;
                        inc_ival  = !ival_ok;
                    end
                end
            end
        end
        if (scan_evt.dup) begin
            inc_desc = 1'b1;
        end
    end
    assign inc_drop = scan_evt.drop;

    always_comb begin
        ep_req.addr  = r_head[2];
        ep_req.ival  = r_head[6];
        ep_req.iface = r_cur_iface;
        ep_req.alt   = r_cur_alt;
        ep_req.ok    = ival_ok;
    end

    ucdw_slot_table #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (clear),
        .i_start  (tbl_start),
        .i_req    (ep_req),
        .i_rd_idx (r_idx),
        .o_evt    (scan_evt),
        .o_rd     (slot_rd)
    );

    // sequencer and walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_state     <= S_IDLE;
            r_bad       <= 1'b0;
            r_started   <= 1'b0;
            r_in_iface  <= 1'b0;
            r_total     <= 16'd0;
            r_rcv       <= 16'd0;
            r_dlen      <= 8'd0;
            r_pos       <= 8'd0;
            r_cur_iface <= 8'd0;
            r_cur_alt   <= 8'd0;
            r_cfg_value <= 8'd0;
            r_dropped   <= 16'd0;
            r_bad_ival  <= 16'd0;
            r_bad_desc  <= 16'd0;
            r_idx       <= '0;
        end else begin
            if (inc_drop && r_dropped != 16'hFFFF) begin
                r_dropped <= r_dropped + 16'd1;
            end
            if (inc_ival && r_bad_ival != 16'hFFFF) begin
                r_bad_ival <= r_bad_ival + 16'd1;
            end
            if (inc_desc && r_bad_desc != 16'hFFFF) begin
                r_bad_desc <= r_bad_desc + 16'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_command == ucdw_pkg::CMD_FEED) begin
                        r_state <= S_FEED;
                    end else if (accept && i_command == ucdw_pkg::CMD_END) begin
                        r_idx   <= '0;
                        r_state <= S_REPORT;
                    end
                end
                S_FEED: begin
                    // advance to the fold only when this byte closes a descriptor
                    if (feed_go && !short_len && closes) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                    if (feed_go) begin
                        r_rcv <= r_rcv + 16'd1;
                        if (short_len) begin
                            r_bad <= 1'b1;
                        end else if (closes) begin
                            r_dlen     <= 8'd0;
                            r_pos      <= 8'd0;
                            r_fold_len <= eff_len;
                        end else begin
                            r_dlen <= eff_len;
                            r_pos  <= pos_inc;
                        end
                    end
                end
                S_FOLD: begin
                    r_state <= tbl_start ? S_SCAN : S_IDLE;
                    if (!r_started) begin
                        if (r_head[1] != ucdw_pkg::TYPE_CONFIG
                                || r_fold_len < ucdw_pkg::CONFIG_LEN
                                || total_from_head < {8'd0, r_fold_len}) begin
                            r_bad <= 1'b1;
                        end else begin
                            r_total     <= total_from_head;
                            r_cfg_value <= r_head[5];
                            r_started   <= 1'b1;
                        end
                    end else if (r_head[1] == ucdw_pkg::TYPE_IFACE) begin
                        if (r_fold_len < ucdw_pkg::IFACE_LEN) begin
                            r_in_iface <= 1'b0;
                        end else begin
                            r_in_iface  <= 1'b1;
                            r_cur_iface <= r_head[2];
                            r_cur_alt   <= r_head[3];
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_evt.done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_REPORT: begin
                    if (!i_stall) begin
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: latch the fed byte, store header bytes, fix the report status
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
        end
        if (r_state == S_FEED && feed_go && !short_len && eff_pos < HEAD_LIM) begin
            r_head[eff_pos[HW-1:0]] <= r_byte;
        end
        if (accept && i_command == ucdw_pkg::CMD_END) begin
            if (r_bad) begin
                r_status <= ucdw_pkg::ST_MALFORMED;
            end else if (!r_started || r_rcv < r_total) begin
                r_status <= ucdw_pkg::ST_PARTIAL;
            end else if (r_dlen != 8'd0) begin
                r_status <= ucdw_pkg::ST_MALFORMED;
            end else begin
                r_status <= ucdw_pkg::ST_COMMIT;
            end
        end
    end

    assign o_valid                = (r_state == S_REPORT);
    assign o_status               = r_status;
    assign o_config_value         = r_cfg_value;
    assign o_slot_used            = slot_rd.used;
    assign o_ep_address           = slot_rd.addr;
    assign o_ep_interval          = slot_rd.ival;
    assign o_ep_interface         = slot_rd.iface;
    assign o_ep_alternate         = slot_rd.alt;
    assign o_ep_unusable          = slot_rd.unusable;
    assign o_dropped_count        = r_dropped;
    assign o_bad_interval_count   = r_bad_ival;
    assign o_bad_descriptor_count = r_bad_desc;
    assign o_last                 = (r_idx == LAST_IDX);

    `UCDW_ASSERT_NEXT(a_last_ends_report, o_valid && !i_stall && o_last, !o_valid, "report overran")
    `UCDW_ASSERT_NOW(a_scan_only_in_scan, scan_evt.done, r_state == S_SCAN, "stray scan event")
    `UCDW_ASSERT_NOW(a_status_code, o_valid, r_status != 2'd3, "bad status code")

endmodule

/* tb/tb.sv */
// Self-checking testbench for usb_config_descriptor_walk: directed table, then random replies.
// Depends on ucdw_pkg and the RTL of usb_config_descriptor_walk; predicts every report item.
`timescale 1ns / 100ps

module tb;

    localparam int          SLOTS       = ucdw_pkg::TABLE_SLOTS_DEF;
    localparam int          HEAD        = ucdw_pkg::HEAD_DEPTH_DEF;
    localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
    localparam int          RANDOM_ITEMS = 210;
    localparam int          IDLE_LIMIT  = 3000;
    localparam int          HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  cfg;
        logic        used;
        logic [7:0]  addr;
        logic [4:0]  ival;
        logic [7:0]  iface;
        logic [7:0]  alt;
        logic        unusable;
        logic [15:0] dropped;
        logic [15:0] bad_ival;
        logic [15:0] bad_desc;
        logic        last;
    } t_slot_report;

    // one row of the directed table; typed_st holds a status readable at a glance
    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
        bit         typed;
        logic [1:0] typed_st;
    } t_walk_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [1:0] i_command = ucdw_pkg::CMD_BEGIN;
    logic [7:0] i_data_byte = 8'd0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_slot_used, o_ep_unusable, o_last;
    logic [1:0] o_status;
    logic [7:0] o_config_value, o_ep_address, o_ep_interface, o_ep_alternate;
    logic [4:0] o_ep_interval;
    logic [15:0] o_dropped_count, o_bad_interval_count, o_bad_descriptor_count;

    usb_config_descriptor_walk dut (.*);

    always #6 i_clk = ~i_clk;

    // walk state mirrored from the block
    logic        w_bad, w_started, w_in_if;
    logic [15:0] w_total, w_rcvd;
    logic [7:0]  w_dlen, w_pos, w_if, w_alt, w_cfg;
    logic [7:0]  w_head [HEAD];
    logic [7:0]  s_addr [SLOTS];
    logic [4:0]  s_ival [SLOTS];
    logic [7:0]  s_if [SLOTS];
    logic [7:0]  s_alt [SLOTS];
    logic        s_unusable [SLOTS];
    logic [15:0] n_dropped, n_bad_ival, n_bad_desc;

    t_slot_report report_q[$];
    int fails = 0;
    int items_sent = 0;
    int reports_sent = 0;
    int slots_checked = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic void clear_walk();
        w_bad = 0; w_started = 0; w_in_if = 0;
        w_total = 0; w_rcvd = 0; w_dlen = 0; w_pos = 0;
        w_if = 0; w_alt = 0; w_cfg = 0;
        foreach (w_head[i]) w_head[i] = 0;
        for (int i = 0; i < SLOTS; i++) begin
            s_addr[i] = 0; s_ival[i] = 0; s_if[i] = 0; s_alt[i] = 0; s_unusable[i] = 0;
        end
        n_dropped = 0; n_bad_ival = 0; n_bad_desc = 0;
    endfunction

    // record an isochronous endpoint: duplicate check first, then first free slot
    function automatic void log_iso_endpoint(input logic [7:0] addr, input logic [7:0] ival);
        bit ok;
        if (addr == 0) begin
            n_bad_desc = sat_inc(n_bad_desc);
            return;
        end
        ok = (ival >= ucdw_pkg::IVAL_MIN && ival <= ucdw_pkg::IVAL_MAX);
        if (!ok) n_bad_ival = sat_inc(n_bad_ival);
        for (int i = 0; i < SLOTS; i++) begin
            if (s_addr[i] == addr && s_if[i] == w_if && s_alt[i] == w_alt) begin
                n_bad_desc = sat_inc(n_bad_desc);
                // stored interval is 0 for a bad one, so compare at full width
                if ({3'b000, s_ival[i]} != ival) s_unusable[i] = 1;
                return;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (s_addr[i] == 0) begin
                s_addr[i] = addr;
                s_ival[i] = ok ? ival[4:0] : 5'd0;
                s_if[i] = w_if;
                s_alt[i] = w_alt;
                s_unusable[i] = !ok;
                return;
            end
        end
        n_dropped = sat_inc(n_dropped);
    endfunction

    function automatic void close_descriptor();
        logic [7:0] dtype;
        dtype = w_head[1];
        if (!w_started) begin
            if (dtype != ucdw_pkg::TYPE_CONFIG || w_dlen < ucdw_pkg::CONFIG_LEN) begin
                w_bad = 1;
                return;
            end
            w_total = {w_head[3], w_head[2]};
            if (w_total < w_dlen) begin
                w_bad = 1;
                return;
            end
            w_cfg = w_head[5];
            w_started = 1;
        end else if (dtype == ucdw_pkg::TYPE_IFACE) begin
            if (w_dlen < ucdw_pkg::IFACE_LEN) begin
                w_in_if = 0;
                n_bad_desc = sat_inc(n_bad_desc);
            end else begin
                w_in_if = 1;
                w_if = w_head[2];
                w_alt = w_head[3];
            end
        end else if (dtype == ucdw_pkg::TYPE_EP) begin
            if (w_dlen < ucdw_pkg::EP_LEN) n_bad_desc = sat_inc(n_bad_desc);
            else if (w_head[3][1:0] != ucdw_pkg::XFER_ISO) return;
            else if (!w_in_if) n_bad_desc = sat_inc(n_bad_desc);
            else log_iso_endpoint(w_head[2], w_head[6]);
        end
    endfunction

    function automatic void feed_walk(input logic [7:0] b);
        if (w_bad) return;
        if (w_started && w_rcvd >= w_total) return;
        w_rcvd = w_rcvd + 16'd1;
        if (w_dlen == 0) begin
            if (b < ucdw_pkg::MIN_LEN) begin
                w_bad = 1;
                return;
            end
            w_dlen = b;
            w_pos = 0;
        end
        if (w_pos < HEAD) w_head[w_pos] = b;
        w_pos = w_pos + 8'd1;
        if (w_pos == w_dlen) begin
            close_descriptor();
            w_dlen = 0;
            w_pos = 0;
        end
    endfunction

    // advance the mirror by one accepted item and queue the report it causes
    function automatic void predict_walk(input logic [1:0] cmd, input logic [7:0] data);
        t_slot_report r;
        logic [1:0] st;
        case (cmd)
            ucdw_pkg::CMD_BEGIN: clear_walk();
            ucdw_pkg::CMD_FEED:  feed_walk(data);
            ucdw_pkg::CMD_END: begin
                if (w_bad) st = ucdw_pkg::ST_MALFORMED;
                else if (!w_started || w_rcvd < w_total) st = ucdw_pkg::ST_PARTIAL;
                else if (w_dlen != 0) st = ucdw_pkg::ST_MALFORMED;
                else st = ucdw_pkg::ST_COMMIT;
                for (int i = 0; i < SLOTS; i++) begin
                    r.status = st; r.cfg = w_cfg; r.used = (s_addr[i] != 0);
                    r.addr = s_addr[i]; r.ival = s_ival[i]; r.iface = s_if[i];
                    r.alt = s_alt[i]; r.unusable = s_unusable[i];
                    r.dropped = n_dropped; r.bad_ival = n_bad_ival; r.bad_desc = n_bad_desc;
                    r.last = (i == SLOTS - 1);
                    report_q.push_back(r);
                end
                reports_sent++;
            end
            default: ;
        endcase
    endfunction

    // offer one item; keep valid high across back-to-back items, drop it only for a gap
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 60) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_stall);
        predict_walk(cmd, data);
        items_sent++;
    endtask

    // receiver side: random stall, plus one long hold-off once a report is offered
    always @(posedge i_clk) begin
        if (hold_req && !hold_done && (hold_cnt > 0 || o_valid)) begin
            i_stall <= 1'b1;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) hold_done = 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endfunction

    // compare each accepted slot item against the oldest queued one
    always @(posedge i_clk) begin
        t_slot_report e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (report_q.size() == 0) begin
                $error("slot item with nothing expected");
                fails++;
            end else begin
                e = report_q.pop_front();
                check_field("status", e.status, o_status);
                check_field("config_value", e.cfg, o_config_value);
                check_field("slot_used", e.used, o_slot_used);
                check_field("ep_address", e.addr, o_ep_address);
                check_field("ep_interval", e.ival, o_ep_interval);
                check_field("ep_interface", e.iface, o_ep_interface);
                check_field("ep_alternate", e.alt, o_ep_alternate);
                check_field("ep_unusable", e.unusable, o_ep_unusable);
                check_field("dropped_count", e.dropped, o_dropped_count);
                check_field("bad_interval_count", e.bad_ival, o_bad_interval_count);
                check_field("bad_descriptor_count", e.bad_desc, o_bad_descriptor_count);
                check_field("last", e.last, o_last);
                slots_checked++;
            end
        end
    end

    // watchdog: end the run when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("usb_config_descriptor_walk test failed");
            $finish;
        end
    end

    // build one reply: header, interfaces with endpoints, odd descriptors, then end
    task automatic send_reply();
        logic [7:0] body[$];
        logic [7:0] addr, ival, attr;
        int total, n_if, n_ep;
        body = {};
        n_if = $urandom_range(1, 3);
        for (int k = 0; k < n_if; k++) begin
            if ($urandom_range(9) == 0)
                body = {body, 8'd5, ucdw_pkg::TYPE_IFACE, 8'd1, 8'd0, 8'd0};
            else body = {body, ucdw_pkg::IFACE_LEN, ucdw_pkg::TYPE_IFACE,
                         8'($urandom_range(2)), 8'($urandom_range(1)),
                         8'd2, 8'd1, 8'd2, 8'd0, 8'd0};
            n_ep = $urandom_range(1, 5);
            for (int j = 0; j < n_ep; j++) begin
                addr = ($urandom_range(11) == 0) ? 8'd0
                     : {1'($urandom_range(1)), 7'($urandom_range(1, 5))};
                ival = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 16));
                attr = 8'($urandom);
                if ($urandom_range(3) != 0) attr[1:0] = ucdw_pkg::XFER_ISO;
                if ($urandom_range(12) == 0)
                    body = {body, 8'd4, ucdw_pkg::TYPE_EP, addr, attr};
                else body = {body, ucdw_pkg::EP_LEN, ucdw_pkg::TYPE_EP, addr, attr,
                             8'($urandom), 8'd0, ival};
            end
            if ($urandom_range(5) == 0) body = {body, 8'd3, 8'($urandom), 8'($urandom)};
        end
        total = body.size() + 9;
        if ($urandom_range(5) == 0) total = total - $urandom_range(1, 5);
        else if ($urandom_range(5) == 0) total = total + $urandom_range(1, 5);
        send_item(ucdw_pkg::CMD_BEGIN, 8'($urandom));
        if ($urandom_range(11) == 0) begin
            // broken start: not a header, or a total below the header length
            body = {8'd9, 8'($urandom_range(1) ? ucdw_pkg::TYPE_IFACE : ucdw_pkg::TYPE_CONFIG),
                    8'd4, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, body};
        end else begin
            body = {ucdw_pkg::CONFIG_LEN, ucdw_pkg::TYPE_CONFIG, 8'(total), 8'(total >> 8),
                    8'(n_if), 8'($urandom), 8'd0, 8'($urandom), 8'($urandom), body};
        end
        if ($urandom_range(7) == 0) body = body[0 : $urandom_range(body.size() - 1)];
        foreach (body[i]) begin
            if ($urandom_range(40) == 0) send_item(CMD_UNKNOWN, 8'($urandom));
            send_item(ucdw_pkg::CMD_FEED, body[i]);
        end
        if ($urandom_range(3) == 0) send_item(ucdw_pkg::CMD_FEED, 8'($urandom));
        send_item(ucdw_pkg::CMD_END, 8'($urandom));
        if ($urandom_range(4) == 0) send_item(ucdw_pkg::CMD_END, 8'($urandom));
    endtask

    t_walk_row walk_rows[] = '{
        '{ucdw_pkg::CMD_END,   8'h00, 1, ucdw_pkg::ST_PARTIAL},
        '{CMD_UNKNOWN,         8'hFF, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'h01, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_END,   8'h00, 1, ucdw_pkg::ST_MALFORMED},
        '{ucdw_pkg::CMD_BEGIN, 8'hAA, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'd9,  0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'd2,  0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'd16, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'd0,  0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'd1,  0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'hFF, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'h00, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'h80, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'h32, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'd7,  0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'd5,  0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'h81, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'h05, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'h00, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'h02, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'd1,  0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_END,   8'h00, 1, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_FEED,  8'h55, 0, ucdw_pkg::ST_COMMIT},
        '{ucdw_pkg::CMD_END,   8'h00, 1, ucdw_pkg::ST_COMMIT}
    };

    initial begin
        int base, waited;
        bit drained;
        drained = 0;
        clear_walk();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: typed status overrides the predicted one for those rows
        foreach (walk_rows[r]) begin
            send_item(walk_rows[r].cmd, walk_rows[r].data);
            if (walk_rows[r].typed && walk_rows[r].cmd == ucdw_pkg::CMD_END)
                for (int i = report_q.size() - SLOTS; i < report_q.size(); i++)
                    report_q[i].status = walk_rows[r].typed_st;
        end

        // random replies through four idling phases
        base = items_sent;
        hold_req = 1;
        while (items_sent - base < RANDOM_ITEMS) begin
            case (((items_sent - base) * 4) / RANDOM_ITEMS)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            send_reply();
            if (!drained || $urandom_range(5) == 0) begin
                // hold the sender until the block has drained every report
                drained = 1;
                i_valid <= 1'b0;
                while (report_q.size() != 0) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        waited = 0;
        while (report_q.size() != 0 && waited < 20 * IDLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (report_q.size() != 0) begin
            $error("%0d slot items never arrived", report_q.size());
            fails++;
        end

        $display("run covered %0d items, %0d end reports, %0d slot items checked",
                 items_sent, reports_sent, slots_checked);
        $display("phases: free flow, sparse sender, stalling receiver, mixed; one long hold-off");
        if (fails == 0) begin
            $display("usb_config_descriptor_walk test passed");
        end else begin
            $display("usb_config_descriptor_walk test failed");
        end
        $finish;
    end
endmodule
